// ===== src/pftd_pkg.sv =====
// ----------------------------------------------------------------------------
// pftd_pkg
// Shared types for the trial-division prime filter: controller commands,
// datapath status and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package pftd_pkg;

  localparam int unsigned PRIME_W = 31;

  // commands from controller to datapath
  typedef struct packed {
    logic load;        // capture the input request
    logic div_start;   // start a division with divisor 2
    logic div_next;    // bump divisor and start the next division
    logic push_prime;  // emit the stored value as a prime result
    logic push_end;    // emit the end marker
  } pftd_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic trivial;     // negative, zero or one: never prime
    logic last;        // stored request was the last one of the list
    logic div_busy;    // division in progress
    logic d_gt_q;      // divisor exceeds quotient: no factor left
    logic rem_zero;    // divisor divides the value
    logic res_full;    // result queue cannot take another entry
  } pftd_sts_t;

  typedef struct packed {
    logic               is_end;
    logic [PRIME_W-1:0] prime_value;
  } pftd_res_t;

endpackage

`default_nettype wire

// ===== src/pftd_ctrl.sv =====
// ----------------------------------------------------------------------------
// pftd_ctrl
// Sequencer: takes one request, steps the divider over divisors 2, 3, ...
// and issues the prime and end-marker results.
// ----------------------------------------------------------------------------
`default_nettype none

module pftd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pftd_pkg::pftd_sts_t sts_i,
  output pftd_pkg::pftd_cmd_t cmd_o
);
  import pftd_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_START  = 6'b000010,
    S_DIV    = 6'b000100,
    S_DECIDE = 6'b001000,
    S_PRIME  = 6'b010000,
    S_END    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_START;
        end
      end
      S_START: begin
        if (sts_i.trivial) begin
          state_d = sts_i.last ? S_END : S_IDLE;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        if (!sts_i.div_busy) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts_i.d_gt_q) begin
          state_d = S_PRIME;
        end else if (sts_i.rem_zero) begin
          state_d = sts_i.last ? S_END : S_IDLE;
        end else begin
          cmd_o.div_next = 1'b1;
          state_d        = S_DIV;
        end
      end
      S_PRIME: begin
        if (!sts_i.res_full) begin
          cmd_o.push_prime = 1'b1;
          state_d          = sts_i.last ? S_END : S_IDLE;
        end
      end
      S_END: begin
        if (!sts_i.res_full) begin
          cmd_o.push_end = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.push_prime || cmd_o.push_end) |-> !sts_i.res_full)
    else $error("result pushed into full queue");

  a_div_cmd_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.div_start || cmd_o.div_next) |=> sts_i.div_busy)
    else $error("division command did not start divider");

  a_trivial_no_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_START && sts_i.trivial) |-> !cmd_o.div_start)
    else $error("division started on a value that cannot be prime");

endmodule

`default_nettype wire

// ===== src/pftd_datapath.sv =====
// ----------------------------------------------------------------------------
// pftd_datapath
// Holds the request, the current divisor and a restoring divider that
// retires one quotient bit per cycle; builds the result records.
// ----------------------------------------------------------------------------
`default_nettype none

module pftd_datapath #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic                  last_i,
  input  pftd_pkg::pftd_cmd_t   cmd_i,
  input  logic                  res_full_i,
  output pftd_pkg::pftd_sts_t   sts_o,
  output pftd_pkg::pftd_res_t   res_o
);
  import pftd_pkg::*;

  localparam int unsigned MAG_W = DATA_WIDTH - 1;
  localparam int unsigned CNT_W = $clog2(MAG_W);

  logic [MAG_W-1:0] mag_q;
  logic             neg_q;
  logic             last_q;
  logic [MAG_W-1:0] div_q, div_d;    // divisor
  logic [MAG_W-1:0] quo_q, quo_d;    // dividend shifting out, quotient in
  logic [MAG_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;

  logic [MAG_W:0]   rem_sh;
  logic [MAG_W:0]   rem_sub;
  logic             take;
  logic [PRIME_W-1:0] prime_val;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q  <= value_i[MAG_W-1:0];
      neg_q  <= value_i[DATA_WIDTH-1];
      last_q <= last_i;
    end
  end

  assign rem_sh  = {rem_q, quo_q[MAG_W-1]};
  assign rem_sub = rem_sh - {1'b0, div_q};
  assign take    = (rem_sh >= {1'b0, div_q});

  always_comb begin
    div_d  = div_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (cmd_i.div_start || cmd_i.div_next) begin
      div_d  = cmd_i.div_start ? MAG_W'(2) : div_q + MAG_W'(1);
      quo_d  = mag_q;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = take ? rem_sub[MAG_W-1:0] : rem_sh[MAG_W-1:0];
      quo_d = {quo_q[MAG_W-2:0], take};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(MAG_W - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  generate
    if (MAG_W >= PRIME_W) begin : g_trunc
      assign prime_val = mag_q[PRIME_W-1:0];
    end else begin : g_ext
      assign prime_val = {{(PRIME_W - MAG_W){1'b0}}, mag_q};
    end
  endgenerate

  assign sts_o.trivial  = neg_q || (mag_q <= MAG_W'(1));
  assign sts_o.last     = last_q;
  assign sts_o.div_busy = busy_q;
  assign sts_o.d_gt_q   = (div_q > quo_q);
  assign sts_o.rem_zero = (rem_q == '0);
  assign sts_o.res_full = res_full_i;

  assign res_o.is_end      = cmd_i.push_end;
  assign res_o.prime_value = cmd_i.push_end ? '0 : prime_val;

  a_busy_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == CNT_W'(MAG_W - 1) && !cmd_i.div_start && !cmd_i.div_next)
      |=> !busy_q)
    else $error("divider ran past its last step");

  a_start_clears_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div_start || cmd_i.div_next) |=> (cnt_q == '0))
    else $error("division started with stale step count");

  a_div_from_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |=> (div_q == MAG_W'(2)))
    else $error("first trial divisor is not two");

endmodule

`default_nettype wire

// ===== src/pftd_res_fifo.sv =====
// ----------------------------------------------------------------------------
// pftd_res_fifo
// Two-entry result queue between the sequencer and the output stream, so a
// new request can be taken while results wait for the sink.
// ----------------------------------------------------------------------------
`default_nettype none

module pftd_res_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pftd_pkg::pftd_res_t data_i,
  output logic                full_o,
  output logic                valid_o,
  input  logic                ready_i,
  output pftd_pkg::pftd_res_t data_o
);
  import pftd_pkg::*;

  pftd_res_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop)    rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("result queue count out of range");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push_i) |=> (count_q == $past(count_q) - 2'd1))
    else $error("result queue count did not drop on pop");

  a_ptrs_match_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("result queue pointers disagree while empty");

endmodule

`default_nettype wire

// ===== src/prime_filter_trial_division.sv =====
// ----------------------------------------------------------------------------
// prime_filter_trial_division
// Stream filter that passes on only the prime values, then an end marker
// after the request flagged tlast.
// ----------------------------------------------------------------------------
// Each request holds one signed DATA_WIDTH-bit value. Negative values, zero
// and one are dropped without a division; a tlast request then also gets
// its end marker. Otherwise the value is divided by 2, 3, 4, ... until a
// divisor divides it or the divisor exceeds the quotient. Each trial runs
// the DATA_WIDTH-1 steps of the bit-serial restoring divider, then a state
// that sees it finish and a decision state. The divider handles one request
// at a time. Results enter a two-entry queue, so the next request is taken
// while earlier results wait on m_axis_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module prime_filter_trial_division #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [((DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,  // [DATA_WIDTH-1:0] value
  input  logic                           s_axis_tlast,  // last
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [31:0]                    m_axis_tdata,  // [30:0] prime_value
  output logic                           m_axis_tlast   // is_end
);
  import pftd_pkg::*;

  pftd_cmd_t cmd;
  pftd_sts_t sts;
  pftd_res_t res_in, res_out;
  logic      res_full;

  pftd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pftd_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .value_i    (s_axis_tdata[DATA_WIDTH-1:0]),
    .last_i     (s_axis_tlast),
    .cmd_i      (cmd),
    .res_full_i (res_full),
    .sts_o      (sts),
    .res_o      (res_in)
  );

  pftd_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd.push_prime || cmd.push_end),
    .data_i  (res_in),
    .full_o  (res_full),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (res_out)
  );

  assign m_axis_tdata = {1'b0, res_out.prime_value};
  assign m_axis_tlast = res_out.is_end;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for the trial-division prime filter. Sends lists of signed values
// on the request stream and predicts each prime and each end marker with its
// own trial-division check. Every accepted result is compared, field by
// field, with the oldest prediction. Both sides stall in short random bursts,
// and the tail of the run has no stalls at all.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pftd_pkg::*;

  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned RAND_REQS = 100;
  localparam int unsigned QUIET_TAIL = 12;
  localparam int unsigned DRAIN_CYCLES = 4 * DATA_WIDTH;
  localparam longint unsigned CYCLE_LIMIT = 10_000_000;

  typedef struct packed {
    logic                  last;
    logic [DATA_WIDTH-1:0] value;
  } req_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [DATA_WIDTH-1:0] s_axis_tdata = '0;   // [DATA_WIDTH-1:0] value
  logic                  s_axis_tlast = 1'b0; // last
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [31:0]           m_axis_tdata;        // [30:0] prime_value
  logic                  m_axis_tlast;        // is_end

  req_t            queued_req[$];
  pftd_res_t       predicted_res[$];
  req_t            next_req;
  pftd_res_t       want;
  int unsigned     total_reqs = 0;
  int unsigned     accepted_reqs = 0;
  int unsigned     errors = 0;
  int unsigned     src_gap = 0;
  int unsigned     sink_gap = 0;
  longint unsigned cycles = 0;

  prime_filter_trial_division #(
    .DATA_WIDTH(DATA_WIDTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic bit is_prime(logic [DATA_WIDTH-1:0] v);
    longint unsigned n;
    longint unsigned d;
    if (v[DATA_WIDTH-1]) return 1'b0;
    n = v;
    if (n <= 1) return 1'b0;
    // d <= n / d keeps the bound inclusive without forming d * d
    for (d = 2; d <= n / d; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic predict_filter(logic [DATA_WIDTH-1:0] value, logic last);
    pftd_res_t res;
    if (is_prime(value)) begin
      res.is_end      = 1'b0;
      res.prime_value = value[PRIME_W-1:0];
      predicted_res.push_back(res);
    end
    if (last) begin
      res.is_end      = 1'b1;
      res.prime_value = '0;
      predicted_res.push_back(res);
    end
  endtask

  function automatic void queue_req(logic [DATA_WIDTH-1:0] value, logic last);
    req_t r;
    r.value = value;
    r.last  = last;
    queued_req.push_back(r);
  endfunction

  // mostly small values, so a request stays cheap; large ones carry a small
  // factor or are negative and get dropped quickly
  function automatic logic [DATA_WIDTH-1:0] rand_value();
    logic [DATA_WIDTH-1:0] v;
    int unsigned           k;
    case ($urandom_range(0, 19))
      0, 1, 2: v = $urandom | {1'b1, {(DATA_WIDTH-1){1'b0}}};
      3, 4, 5: begin
        k = $urandom_range(2, 7);
        v = $urandom;
        v[DATA_WIDTH-1] = 1'b0;
        v = v - (v % k);
      end
      6: v = $urandom_range(0, 1 << 18);
      default: v = $urandom_range(0, 2000);
    endcase
    return v;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_filter(s_axis_tdata, s_axis_tlast);
        accepted_reqs++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap != 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (queued_req.size() != 0) begin
          next_req = queued_req.pop_front();
          s_axis_tdata  <= next_req.value;
          s_axis_tlast  <= next_req.last;
          s_axis_tvalid <= 1'b1;
          if (queued_req.size() >= QUIET_TAIL && $urandom_range(0, 4) == 0)
            src_gap = $urandom_range(1, 3);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and sink stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (predicted_res.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, actual prime_value %0d is_end %0b",
                   $time, m_axis_tdata[PRIME_W-1:0], m_axis_tlast);
        end else begin
          want = predicted_res.pop_front();
          if (m_axis_tdata[PRIME_W-1:0] !== want.prime_value) begin
            errors++;
            $display("%0t: prime_value mismatch: expected %0d, actual %0d",
                     $time, want.prime_value, m_axis_tdata[PRIME_W-1:0]);
          end
          if (m_axis_tlast !== want.is_end) begin
            errors++;
            $display("%0t: is_end mismatch: expected %0b, actual %0b",
                     $time, want.is_end, m_axis_tlast);
          end
        end
      end
      if (sink_gap != 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (queued_req.size() >= QUIET_TAIL && $urandom_range(0, 3) == 0)
          sink_gap = $urandom_range(1, 3);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned n_left;
    int unsigned list_len;

    queue_req(32'h8000_0000, 1'b0);  // most negative
    queue_req(32'hFFFF_FFFF, 1'b1);  // list with no prime: end marker alone
    queue_req(32'd0, 1'b0);
    queue_req(32'd1, 1'b0);
    queue_req(32'd2, 1'b0);
    queue_req(32'd3, 1'b0);
    queue_req(32'd4, 1'b0);
    queue_req(32'd25, 1'b0);         // square of a prime
    queue_req(32'd49, 1'b0);
    queue_req(32'd65521, 1'b0);
    queue_req(32'h5555_5555, 1'b0);
    queue_req(32'h2AAA_AAAA, 1'b0);
    queue_req(32'h7FFF_FFFE, 1'b0);
    queue_req(32'h7FFF_FFFF, 1'b1);  // largest value is prime: prime then end marker
    queue_req(32'd7, 1'b1);          // single-request list, prime
    queue_req(32'd1, 1'b1);          // single-request list, dropped

    n_left = RAND_REQS;
    while (n_left > 0) begin
      list_len = $urandom_range(1, 8);
      if (list_len > n_left) list_len = n_left;
      for (int i = 0; i < list_len; i++)
        queue_req(rand_value(), i == list_len - 1);
      n_left -= list_len;
    end
    total_reqs = queued_req.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_reqs != total_reqs) @(posedge clk_i);
    while (predicted_res.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== prime_filter_trial_division.f =====
src/pftd_pkg.sv
src/pftd_ctrl.sv
src/pftd_datapath.sv
src/pftd_res_fifo.sv
src/prime_filter_trial_division.sv
dv/tb.sv
